// ----- src/escalating_threshold_alarm_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef ESCALATING_THRESHOLD_ALARM_UNIT_DEFINES_SVH
`define ESCALATING_THRESHOLD_ALARM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ETA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ETA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/eta_pkg.sv -----
// Types and constants for the escalating threshold alarm unit.
package eta_pkg;

  localparam int unsigned MV_W    = 12;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 2'd3;
  localparam logic [CNT_W-1:0]   CNT_SAT   = 8'd255;

  typedef enum logic [1:0] {
    REQ_SAMPLE   = 2'd0,
    REQ_LVL_UP   = 2'd1,
    REQ_LVL_DOWN = 2'd2,
    REQ_TMR_RST  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ENTER    = 3'd1,
    EV_AUTO_UP  = 3'd2,
    EV_RECOVER  = 3'd3,
    EV_MAN_UP   = 3'd4,
    EV_MAN_DOWN = 3'd5,
    EV_TMR_RST  = 3'd6
  } event_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_ALARM  = 3'd0,
    CFG_HIGH_ALARM = 3'd1,
    CFG_LOW_CLEAR  = 3'd2,
    CFG_HIGH_CLEAR = 3'd3,
    CFG_ESC_TICKS  = 3'd4,
    CFG_RECOVER    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [MV_W-1:0] sense_mv;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         event_code;
    logic               alarm_active;
    logic [LEVEL_W-1:0] cur_level;
  } out_res_t;

endpackage

// ----- src/escalating_threshold_alarm_unit.sv -----
// Escalating threshold alarm: sample/key requests in, one event result per request out.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in_     | input     | in_valid/in_stall  | in_data  (req_type, sense_mv)
//  out_    | output    | out_valid/out_stall| out_data (event_code, alarm_active, cur_level)
//  cfg_    | input     | cfg_we             | cfg_idx, cfg_wdata (write only)
//
// Flow: one request per clock while in_stall is low. The result lands in the output register
// in the cycle after the request is taken; the whole state update is one compare/increment
// pass set by the alarm state registers, so the next request sees it at once.
// Reset: synchronous, rst_n low; state, valid and config registers return to defaults, alarm normal.
// Stalls: in_stall is high only while a result sits in the output register and
// out_stall holds it, so the output register works as the only buffer stage.
module escalating_threshold_alarm_unit
  import eta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_res_t             out_data,
  // register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [MV_W-1:0]      cfg_wdata
);

  // configuration registers
  logic [MV_W-1:0]  low_alarm_r,  high_alarm_r;
  logic [MV_W-1:0]  low_clear_r,  high_clear_r;
  logic [CNT_W-1:0] esc_ticks_r,  recover_r;

  // alarm state
  logic               active_r,  active_nxt;
  logic [LEVEL_W-1:0] level_r,   level_nxt;
  logic [CNT_W-1:0]   elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]   stable_r,  stable_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  out_res_t    out_data_r;
  event_code_t ev;

  logic in_accept;

  // helper values for a sample request
  logic [CNT_W-1:0] thr;
  logic [CNT_W-1:0] elapsed_inc;
  logic [CNT_W-1:0] stable_inc;
  logic             outside_alarm;
  logic             inside_clear;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign thr = (esc_ticks_r == '0) ? CNT_W'(1) : esc_ticks_r;
  // tick advances the timer only while alarmed, saturating
  assign elapsed_inc = (active_r && elapsed_r != CNT_SAT) ? elapsed_r + CNT_W'(1) : elapsed_r;
  assign stable_inc  = (stable_r != CNT_SAT) ? stable_r + CNT_W'(1) : stable_r;

  assign outside_alarm = (in_data.sense_mv < low_alarm_r) || (in_data.sense_mv > high_alarm_r);
  assign inside_clear  = (in_data.sense_mv >= low_clear_r) &&
                         (in_data.sense_mv <= high_clear_r);

  // next alarm state and event for the request at the input
  always_comb begin
    active_nxt  = active_r;
    level_nxt   = level_r;
    elapsed_nxt = elapsed_r;
    stable_nxt  = stable_r;
    ev          = EV_NONE;
    unique case (req_type_t'(in_data.req_type))
      REQ_SAMPLE: begin
        elapsed_nxt = elapsed_inc;
        if (outside_alarm) begin
          stable_nxt = '0;
          if (!active_r) begin
            // fresh entry; timer restarts so escalation cannot follow on this request
            active_nxt  = 1'b1;
            level_nxt   = LEVEL_W'(1);
            elapsed_nxt = '0;
            ev          = EV_ENTER;
          end else if (elapsed_inc >= thr && level_r < MAX_LEVEL) begin
            level_nxt   = level_r + LEVEL_W'(1);
            elapsed_nxt = '0;
            ev          = EV_AUTO_UP;
          end
        end else if (active_r) begin
          if (inside_clear) begin
            if (stable_inc >= recover_r) begin
              active_nxt = 1'b0;
              level_nxt  = '0;
              stable_nxt = '0;
              ev         = EV_RECOVER;
            end else begin
              stable_nxt = stable_inc;
            end
          end else begin
            // between clear band and alarm band: recovery run broken
            stable_nxt = '0;
          end
        end
      end
      REQ_LVL_UP: begin
        if (active_r && level_r < MAX_LEVEL) begin
          level_nxt   = level_r + LEVEL_W'(1);
          elapsed_nxt = '0;
          ev          = EV_MAN_UP;
        end
      end
      REQ_LVL_DOWN: begin
        if (active_r && level_r > LEVEL_W'(1)) begin
          level_nxt   = level_r - LEVEL_W'(1);
          elapsed_nxt = '0;
          ev          = EV_MAN_DOWN;
        end
      end
      REQ_TMR_RST: begin
        if (active_r) begin
          elapsed_nxt = '0;
          ev          = EV_TMR_RST;
        end
      end
    endcase
  end

  // output register holds until taken; a new request may refill it the same cycle
  always_comb begin
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      level_r     <= '0;
      elapsed_r   <= '0;
      stable_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        active_r  <= active_nxt;
        level_r   <= level_nxt;
        elapsed_r <= elapsed_nxt;
        stable_r  <= stable_nxt;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r.event_code   <= ev;
      out_data_r.alarm_active <= active_nxt;
      out_data_r.cur_level    <= level_nxt;
    end
  end

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_alarm_r  <= MV_W'(1000);
      high_alarm_r <= MV_W'(2300);
      low_clear_r  <= MV_W'(1100);
      high_clear_r <= MV_W'(2200);
      esc_ticks_r  <= CNT_W'(20);
      recover_r    <= CNT_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LOW_ALARM:  low_alarm_r  <= cfg_wdata;
        CFG_HIGH_ALARM: high_alarm_r <= cfg_wdata;
        CFG_LOW_CLEAR:  low_clear_r  <= cfg_wdata;
        CFG_HIGH_CLEAR: high_clear_r <= cfg_wdata;
        CFG_ESC_TICKS:  esc_ticks_r  <= cfg_wdata[CNT_W-1:0];
        CFG_RECOVER:    recover_r    <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/eta_checker.sv -----
// Port-level checker for the escalating threshold alarm unit, with its bind.
`include "escalating_threshold_alarm_unit_defines.svh"

module eta_checker
  import eta_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_res_t out_data
);

  logic lvl_ok;
  logic ev_enter;
  logic enter_ok;
  logic ev_recover;
  logic in_take;
  logic out_held;

  assign lvl_ok     = (out_data.alarm_active == (out_data.cur_level != '0));
  assign ev_enter   = out_valid && (out_data.event_code == EV_ENTER);
  assign enter_ok   = out_data.alarm_active && (out_data.cur_level == LEVEL_W'(1));
  assign ev_recover = out_valid && (out_data.event_code == EV_RECOVER);
  assign in_take    = in_valid && !in_stall;
  assign out_held   = out_valid && out_stall;

  // normal state always reports level zero, alarm state never does
  `ETA_ASSERT_NOW(a_level_matches_active, out_valid, lvl_ok, "level disagrees with active")

  // entry always lands on level one
  `ETA_ASSERT_NOW(a_enter_level, ev_enter, enter_ok, "entry not at level one")

  // recovery leaves the alarm normal
  `ETA_ASSERT_NOW(a_recover_clears, ev_recover, !out_data.alarm_active, "recover left alarm on")

  // a request taken always produces a result next cycle
  `ETA_ASSERT_NEXT(a_result_follows, in_take, out_valid, "accepted request gave no result")

  // held result stays put
  `ETA_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled result moved")

endmodule

bind escalating_threshold_alarm_unit eta_checker u_eta_checker (.*);
